// ===== rtl/odr_pkg.sv =====
// ----------------------------------------------------------------------------
// odr_pkg
// Shared types, constants and tables of the dead-reckoning pose integrator.
// ----------------------------------------------------------------------------
package odr_pkg;

  localparam int TABLE_LEN         = 24;
  localparam int STEP_W            = 5;
  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int POSITION_BITS_DEF = 48;

  localparam int IO_POS_W  = 48;
  localparam int ANG_W     = 16;
  localparam int SPEED_W   = 16;
  localparam int TICK_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam int IN_DATA_W  = ANG_W + 2 * SPEED_W;
  localparam int OUT_DATA_W = 2 * IO_POS_W + ANG_W;

  // Q4.30 CORDIC working width and the angle accumulator width.
  localparam int CX_W = 34;
  localparam int CZ_W = 33;

  localparam logic signed [CX_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic signed [IO_POS_W-1:0] START_RESET = 48'sd250000000;
  localparam logic [TICK_W-1:0]          TICK_RESET  = 16'd5000;

  localparam logic CMD_CAPTURE   = 1'b0;
  localparam logic CMD_INTEGRATE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X = 2'd0,
    REG_START_Y = 2'd1,
    REG_TICK    = 2'd2
  } odr_reg_e;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_LOAD  = 9'b000000010,
    ST_PREP  = 9'b000000100,
    ST_ROT   = 9'b000001000,
    ST_ROUND = 9'b000010000,
    ST_MULX  = 9'b000100000,
    ST_MULY  = 9'b001000000,
    ST_ACCY  = 9'b010000000,
    ST_OUT   = 9'b100000000
  } odr_state_e;

  typedef struct packed {
    logic              load_item;
    logic              capture;
    logic              prep;
    logic              rot_step;
    logic [STEP_W-1:0] step;
    logic              round;
    logic              mul_x;
    logic              mul_y;
    logic              acc_y;
    logic              load_out;
  } odr_cmd_t;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [29:0] atan_turn32(input logic [STEP_W-1:0] idx);
    logic [29:0] a;
    case (idx)
      5'd0:    a = 30'd536870912;
      5'd1:    a = 30'd316933406;
      5'd2:    a = 30'd167458907;
      5'd3:    a = 30'd85004756;
      5'd4:    a = 30'd42667331;
      5'd5:    a = 30'd21354465;
      5'd6:    a = 30'd10679838;
      5'd7:    a = 30'd5340245;
      5'd8:    a = 30'd2670163;
      5'd9:    a = 30'd1335087;
      5'd10:   a = 30'd667544;
      5'd11:   a = 30'd333772;
      5'd12:   a = 30'd166886;
      5'd13:   a = 30'd83443;
      5'd14:   a = 30'd41722;
      5'd15:   a = 30'd20861;
      5'd16:   a = 30'd10430;
      5'd17:   a = 30'd5215;
      5'd18:   a = 30'd2608;
      5'd19:   a = 30'd1304;
      5'd20:   a = 30'd652;
      5'd21:   a = 30'd326;
      5'd22:   a = 30'd163;
      5'd23:   a = 30'd81;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/odr_ctrl.sv =====
// ----------------------------------------------------------------------------
// odr_ctrl
// Sequencer of the pose integrator: accepts requests, walks the CORDIC steps
// and the multiply/accumulate phases, and owns the result valid flag.
// ----------------------------------------------------------------------------
module odr_ctrl import odr_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     in_cmd_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output odr_cmd_t cmd_o
);

  localparam int EFF_STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(EFF_STEPS - 1);

  odr_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.step  = step_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = (in_cmd_i == CMD_CAPTURE) ? ST_LOAD : ST_PREP;
        end
      end
      ST_LOAD: begin
        cmd_o.capture = 1'b1;
        state_d = ST_OUT;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        step_d  = '0;
        state_d = ST_ROT;
      end
      ST_ROT: begin
        cmd_o.rot_step = 1'b1;
        if (step_q == LAST_STEP) begin
          state_d = ST_ROUND;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d = ST_MULX;
      end
      ST_MULX: begin
        cmd_o.mul_x = 1'b1;
        state_d = ST_MULY;
      end
      ST_MULY: begin
        cmd_o.mul_y = 1'b1;
        state_d = ST_ACCY;
      end
      ST_ACCY: begin
        cmd_o.acc_y = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // The finished pose waits here until the output register frees up.
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/odr_datapath.sv =====
// ----------------------------------------------------------------------------
// odr_datapath
// Registers and arithmetic of the pose integrator: configuration, heading,
// step length, iterative CORDIC, shared multiplier and saturating position.
// ----------------------------------------------------------------------------
module odr_datapath import odr_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  odr_cmd_t                    cmd_i,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [IO_POS_W-1:0]         cfg_data_i,
  input  logic                        item_cmd_i,
  input  logic [ANG_W-1:0]            item_raw_i,
  input  logic [SPEED_W-1:0]          item_left_i,
  input  logic [SPEED_W-1:0]          item_right_i,
  output logic [IO_POS_W-1:0]         pos_x_o,
  output logic [IO_POS_W-1:0]         pos_y_o,
  output logic [ANG_W-1:0]            heading_o
);

  localparam int PB = POSITION_BITS;
  localparam logic signed [64:0] PMAX = $signed({1'b0, {64{1'b1}}} >> (65 - PB));
  localparam logic signed [64:0] PMIN = -PMAX - 65'sd1;

  function automatic logic signed [PB-1:0] clamp_pos(input logic signed [64:0] v);
    logic signed [PB-1:0] r;
    if (v > PMAX) begin
      r = PB'(PMAX);
    end else if (v < PMIN) begin
      r = PB'(PMIN);
    end else begin
      r = PB'(v);
    end
    return r;
  endfunction

  // Adds the product shifted right by 15 and saturates to the position range.
  function automatic logic signed [PB-1:0] sat_add(input logic signed [PB-1:0] p,
                                                   input logic signed [47:0] prod);
    logic signed [32:0] delta;
    logic signed [64:0] sum;
    delta = prod[47:15];
    sum   = 65'(p) + 65'(delta);
    return clamp_pos(sum);
  endfunction

  function automatic logic signed [15:0] to_q15(input logic signed [CX_W-1:0] v);
    logic signed [CX_W:0] t;
    logic signed [19:0]   r;
    logic signed [15:0]   q;
    t = (CX_W+1)'(v) + (CX_W+1)'(16384);
    r = 20'(t >>> 15);
    if (r > 20'sd32767) begin
      q = 16'sd32767;
    end else if (r < -20'sd32768) begin
      q = -16'sd32768;
    end else begin
      q = 16'(r);
    end
    return q;
  endfunction

  // Configuration and state.
  logic signed [IO_POS_W-1:0] start_x_q, start_y_q;
  logic [TICK_W-1:0]          tick_q;
  logic [ANG_W-1:0]           ref_q;
  logic [ANG_W-1:0]           heading_q;
  logic signed [PB-1:0]       pos_x_q, pos_y_q;

  // Working registers.
  logic                       cmd_q;
  logic [ANG_W-1:0]           raw_q;
  logic signed [SPEED_W-1:0]  left_q, right_q;
  logic signed [31:0]         ds_q;
  logic signed [CX_W-1:0]     cx_q, cy_q;
  logic signed [CZ_W-1:0]     cz_q;
  logic                       flip_q;
  logic signed [15:0]         cos_q, sin_q;
  logic signed [47:0]         prod_q;
  logic [IO_POS_W-1:0]        out_x_q, out_y_q;
  logic [ANG_W-1:0]           out_h_q;

  // Step preparation.
  logic [ANG_W-1:0]           heading_new;
  logic signed [ANG_W-1:0]    head_s;
  logic                       fold;
  logic [ANG_W-1:0]           ang_fold;
  logic signed [16:0]         speed_sum;
  logic signed [16:0]         tick_s;
  logic signed [33:0]         ds_prod;

  assign heading_new = raw_q - ref_q;
  assign head_s      = $signed(heading_new);
  assign fold        = (head_s > 16'sd16384) || (head_s < -16'sd16384);
  assign ang_fold    = fold ? (heading_new ^ 16'h8000) : heading_new;
  assign speed_sum   = 17'(left_q) + 17'(right_q);
  assign tick_s      = $signed({1'b0, tick_q});
  assign ds_prod     = speed_sum * tick_s;

  // One CORDIC rotation.
  logic signed [CX_W-1:0] sh_x, sh_y;
  logic signed [CZ_W-1:0] atan_s;

  assign sh_x   = cy_q >>> cmd_i.step;
  assign sh_y   = cx_q >>> cmd_i.step;
  assign atan_s = $signed({3'b000, atan_turn32(cmd_i.step)});

  logic signed [CX_W-1:0] vx, vy;
  assign vx = flip_q ? -cx_q : cx_q;
  assign vy = flip_q ? -cy_q : cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= START_RESET;
      start_y_q <= START_RESET;
      tick_q    <= TICK_RESET;
      ref_q     <= '0;
      heading_q <= '0;
      pos_x_q   <= clamp_pos(65'(START_RESET));
      pos_y_q   <= clamp_pos(65'(START_RESET));
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_START_X: start_x_q <= $signed(cfg_data_i);
          REG_START_Y: start_y_q <= $signed(cfg_data_i);
          REG_TICK:    tick_q    <= cfg_data_i[TICK_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.capture) begin
        ref_q     <= raw_q;
        heading_q <= '0;
        pos_x_q   <= clamp_pos(65'(start_x_q));
        pos_y_q   <= clamp_pos(65'(start_y_q));
      end
      if (cmd_i.prep) begin
        heading_q <= heading_new;
      end
      if (cmd_i.mul_y) begin
        pos_x_q <= sat_add(pos_x_q, prod_q);
      end
      if (cmd_i.acc_y) begin
        pos_y_q <= sat_add(pos_y_q, prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      cmd_q   <= item_cmd_i;
      raw_q   <= item_raw_i;
      left_q  <= $signed(item_left_i);
      right_q <= $signed(item_right_i);
    end
    if (cmd_i.prep) begin
      ds_q   <= ds_prod[32:1];
      flip_q <= fold;
      cx_q   <= CORDIC_GAIN_Q30;
      cy_q   <= '0;
      cz_q   <= $signed({ang_fold[ANG_W-1], ang_fold, 16'h0000});
    end
    if (cmd_i.rot_step) begin
      if (!cz_q[CZ_W-1]) begin
        cx_q <= cx_q - sh_x;
        cy_q <= cy_q + sh_y;
        cz_q <= cz_q - atan_s;
      end else begin
        cx_q <= cx_q + sh_x;
        cy_q <= cy_q - sh_y;
        cz_q <= cz_q + atan_s;
      end
    end
    if (cmd_i.round) begin
      cos_q <= to_q15(vx);
      sin_q <= to_q15(vy);
    end
    if (cmd_i.mul_x) begin
      prod_q <= ds_q * cos_q;
    end
    if (cmd_i.mul_y) begin
      prod_q <= ds_q * sin_q;
    end
    if (cmd_i.load_out) begin
      out_x_q <= IO_POS_W'(65'(pos_x_q));
      out_y_q <= IO_POS_W'(65'(pos_y_q));
      out_h_q <= (cmd_q == CMD_CAPTURE) ? '0 : heading_q;
    end
  end

  assign pos_x_o   = out_x_q;
  assign pos_y_o   = out_y_q;
  assign heading_o = out_h_q;

endmodule

// ===== rtl/odometry_dead_reckoning_top.sv =====
// ----------------------------------------------------------------------------
// odometry_dead_reckoning_top
// Differential-drive dead-reckoning pose integrator with CORDIC heading.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                    Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tuser: command, tdata: heading, speeds
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: pos_x, pos_y, heading
//  cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
//  An integrate request runs through preparation, the CORDIC rotations at one
//  step per cycle, rounding, the two multiplies and the accumulate; a capture
//  request loads the reference and start pose. The result sits in an output register,
//  so the next request is accepted while the previous pose is still waiting;
//  a stalled output holds the block only when a second pose is finished.
//  Reset is asynchronous and loads the start pose with a zero heading.
// ----------------------------------------------------------------------------
module odometry_dead_reckoning_top import odr_pkg::*; #(
  parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // raw_heading, speed_left, speed_right
  input  logic [0:0]             s_axis_tuser,   // command
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // pos_x, pos_y, heading
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [IO_POS_W-1:0]    cfg_data_i
);

  odr_cmd_t            cmd;
  logic [IO_POS_W-1:0] pos_x, pos_y;
  logic [ANG_W-1:0]    heading;
  logic                in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = s_axis_tvalid && s_axis_tready;

  odr_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser[0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  odr_datapath #(
    .POSITION_BITS(POSITION_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .item_cmd_i   (s_axis_tuser[0]),
    .item_raw_i   (s_axis_tdata[ANG_W-1:0]),
    .item_left_i  (s_axis_tdata[ANG_W+SPEED_W-1:ANG_W]),
    .item_right_i (s_axis_tdata[IN_DATA_W-1:ANG_W+SPEED_W]),
    .pos_x_o      (pos_x),
    .pos_y_o      (pos_y),
    .heading_o    (heading)
  );

  assign m_axis_tdata = {heading, pos_y, pos_x};

  // The block is busy right after taking a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("request accepted while a previous one is still in work");

  // A new result only appears at the end of a request's work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised without a request in work");

  // The sequencer never loads the output register over an unconsumed result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten while full");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dead-reckoning pose integrator. A directed table
// walks the heading folds, speed extremes, saturation, zero tick and register
// timing, then random phases under changing settings follow. Every pose is
// checked against its typed table row or the in-bench CORDIC/integrator model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench import odr_pkg::*; ();

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint POS_HI = (64'sd1 <<< (POSITION_BITS_DEF - 1)) - 64'sd1;
  localparam longint POS_LO = -POS_HI - 64'sd1;
  localparam longint START_DEFAULT = 250000000;
  localparam int ROT_STEPS = (CORDIC_STEPS_DEF > 24) ? 24 : CORDIC_STEPS_DEF;
  localparam int LONG_HOLD = 400;
  localparam longint ATAN_TURN [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  typedef struct packed {
    logic [IO_POS_W-1:0] pos_x;
    logic [IO_POS_W-1:0] pos_y;
    logic [ANG_W-1:0]    heading;
  } pose_t;

  typedef struct packed {
    logic  typed;
    pose_t pose;
  } pose_want_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [IO_POS_W-1:0]  data;
    logic                 cmd;
    logic [ANG_W-1:0]     raw;
    logic [SPEED_W-1:0]   sl;
    logic [SPEED_W-1:0]   sr;
    logic                 typed;
    pose_t                want;
  } step_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [IO_POS_W-1:0]   cfg_data_i = '0;

  // Model copy of the registers and of the pose state.
  longint                cfg_start_x = START_DEFAULT;
  longint                cfg_start_y = START_DEFAULT;
  logic [TICK_W-1:0]     cfg_tick = 16'd5000;
  logic signed [ANG_W-1:0] st_ref = '0;
  logic signed [ANG_W-1:0] st_heading = '0;
  longint                st_x = START_DEFAULT;
  longint                st_y = START_DEFAULT;

  pose_t                 expected_poses[$];
  pose_want_t            directed_wants[$];
  step_row_t             directed_rows[$];
  int                    error_count = 0;
  bit                    tx_quiet = 1'b0;
  bit                    rx_quiet = 1'b0;
  bit                    rx_hold_req = 1'b0;

  odometry_dead_reckoning_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint clamp_position(longint v);
    if (v > POS_HI) return POS_HI;
    if (v < POS_LO) return POS_LO;
    return v;
  endfunction

  function automatic logic signed [15:0] round_q15(longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 32767) return 16'sh7fff;
    if (r < -32768) return 16'sh8000;
    return r[15:0];
  endfunction

  // Returns {cos, sin} in Q1.15 for a 16-bit binary angle.
  function automatic logic [31:0] cordic_cos_sin(logic signed [ANG_W-1:0] ang);
    logic signed [ANG_W-1:0] a;
    longint x, y, z, dx, dy;
    bit flip;
    a = ang;
    flip = 1'b0;
    // Angles beyond a quarter turn are folded by a half turn and negated after.
    if (a > 16384 || a < -16384) begin
      a = a + 16'sh8000;
      flip = 1'b1;
    end
    x = 652032874;
    y = 0;
    z = longint'(a) * 65536;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURN[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    return {round_q15(x), round_q15(y)};
  endfunction

  function automatic pose_t predict_pose(logic cmd, logic signed [ANG_W-1:0] raw,
                                         logic signed [SPEED_W-1:0] sl,
                                         logic signed [SPEED_W-1:0] sr);
    longint ds;
    logic [31:0] cs;
    logic signed [15:0] c, s;
    pose_t p;
    if (cmd == CMD_CAPTURE) begin
      st_ref = raw;
      st_heading = '0;
      st_x = clamp_position(cfg_start_x);
      st_y = clamp_position(cfg_start_y);
    end else begin
      st_heading = raw - st_ref;
      ds = ((longint'(sl) + longint'(sr)) * longint'(cfg_tick)) >>> 1;
      cs = cordic_cos_sin(st_heading);
      c = cs[31:16];
      s = cs[15:0];
      st_x = clamp_position(st_x + ((ds * longint'(c)) >>> 15));
      st_y = clamp_position(st_y + ((ds * longint'(s)) >>> 15));
    end
    p.pos_x = st_x[IO_POS_W-1:0];
    p.pos_y = st_y[IO_POS_W-1:0];
    p.heading = st_heading;
    return p;
  endfunction

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Checks returned poses, follows register writes and predicts accepted requests.
  always @(posedge clk_i) begin
    pose_t got, want, pred;
    pose_want_t dw;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.pos_x = m_axis_tdata[IO_POS_W-1:0];
        got.pos_y = m_axis_tdata[2*IO_POS_W-1:IO_POS_W];
        got.heading = m_axis_tdata[OUT_DATA_W-1:2*IO_POS_W];
        if (expected_poses.size() == 0) begin
          report_error($sformatf("unexpected pose x %h y %h heading %h",
                                 got.pos_x, got.pos_y, got.heading));
        end else begin
          want = expected_poses.pop_front();
          if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
              got.heading !== want.heading) begin
            report_error($sformatf(
              "pose mismatch: x exp %h got %h, y exp %h got %h, heading exp %h got %h",
              want.pos_x, got.pos_x, want.pos_y, got.pos_y, want.heading, got.heading));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_START_X: cfg_start_x = $signed(cfg_data_i);
          REG_START_Y: cfg_start_y = $signed(cfg_data_i);
          REG_TICK:    cfg_tick = cfg_data_i[TICK_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pred = predict_pose(s_axis_tuser[0], s_axis_tdata[ANG_W-1:0],
                            s_axis_tdata[ANG_W+SPEED_W-1:ANG_W],
                            s_axis_tdata[IN_DATA_W-1:ANG_W+SPEED_W]);
        if (directed_wants.size() != 0) begin
          dw = directed_wants.pop_front();
          if (dw.typed) pred = dw.pose;
        end
        expected_poses.push_back(pred);
      end
    end
  end

  // Receiver: random hold-off per pose, plus one long stall on request.
  initial begin
    int hold;
    forever begin
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      hold = rx_quiet ? 0 : $urandom_range(0, 11);
      if (hold != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  task automatic offer_item(logic cmd, logic [ANG_W-1:0] raw,
                            logic [SPEED_W-1:0] sl, logic [SPEED_W-1:0] sr);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {sr, sl, raw};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stops offering and waits until every outstanding pose has come back.
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_poses.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [IO_POS_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic row_cfg(logic [CFG_IDX_W-1:0] idx, longint data);
    step_row_t r;
    r = '{kind: ROW_CFG, default: '0};
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data[IO_POS_W-1:0];
    directed_rows.push_back(r);
  endtask

  task automatic row_item(logic typed, logic cmd, int raw, int sl, int sr,
                          longint x, longint y, int h);
    step_row_t r;
    r = '{kind: ROW_ITEM, default: '0};
    r.kind = ROW_ITEM;
    r.cmd = cmd;
    r.raw = raw[ANG_W-1:0];
    r.sl = sl[SPEED_W-1:0];
    r.sr = sr[SPEED_W-1:0];
    r.typed = typed;
    r.want.pos_x = x[IO_POS_W-1:0];
    r.want.pos_y = y[IO_POS_W-1:0];
    r.want.heading = h[ANG_W-1:0];
    directed_rows.push_back(r);
  endtask

  function automatic logic [SPEED_W-1:0] draw_speed();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 4000) - 2000;
      1: v = $urandom_range(0, 1) ? 32767 : -32768;
      default: v = $urandom;
    endcase
    return v[SPEED_W-1:0];
  endfunction

  function automatic longint draw_start();
    logic [IO_POS_W-1:0] bits;
    longint r;
    case ($urandom_range(0, 3))
      0: r = $urandom_range(0, 1) ? POS_HI : POS_LO;
      1: begin
        bits = IO_POS_W'({$urandom, $urandom});
        r = $signed(bits);
      end
      2: r = longint'($urandom_range(0, 2000000)) - 1000000;
      default: r = START_DEFAULT;
    endcase
    return r;
  endfunction

  initial begin
    step_row_t row;
    logic cmd;
    int tick;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state first, then the quarter-turn fold boundaries and wrap.
    row_item(1, CMD_INTEGRATE, 0, 0, 0, START_DEFAULT, START_DEFAULT, 0);
    row_item(1, CMD_CAPTURE, -32768, 0, 0, START_DEFAULT, START_DEFAULT, 0);
    row_item(1, CMD_INTEGRATE, -32768, 0, 0, START_DEFAULT, START_DEFAULT, 0);
    row_item(1, CMD_CAPTURE, 0, 123, -456, START_DEFAULT, START_DEFAULT, 0);
    row_item(0, CMD_INTEGRATE, 16384, 32767, 32767, 0, 0, 0);
    row_item(0, CMD_INTEGRATE, 16385, -32768, -32768, 0, 0, 0);
    row_item(0, CMD_INTEGRATE, -16384, 32767, -32768, 0, 0, 0);
    row_item(0, CMD_INTEGRATE, -16385, 1000, 3000, 0, 0, 0);
    row_item(0, CMD_INTEGRATE, 32767, -500, 200, 0, 0, 0);
    row_item(0, CMD_INTEGRATE, -32768, 32767, 0, 0, 0, 0);
    row_item(1, CMD_CAPTURE, 32767, 0, 0, START_DEFAULT, START_DEFAULT, 0);
    row_item(0, CMD_INTEGRATE, -32768, 100, 100, 0, 0, 0);
    // New start values only apply at the next capture; then both axes saturate.
    row_cfg(REG_TICK, 65535);
    row_cfg(REG_START_X, POS_HI);
    row_cfg(REG_START_Y, POS_LO);
    row_item(0, CMD_INTEGRATE, 0, 500, 500, 0, 0, 0);
    row_item(1, CMD_CAPTURE, 0, 0, 0, POS_HI, POS_LO, 0);
    row_item(0, CMD_INTEGRATE, 0, 32767, 32767, 0, 0, 0);
    row_item(0, CMD_INTEGRATE, -16384, 32767, 32767, 0, 0, 0);
    row_item(0, CMD_INTEGRATE, 8192, -32768, -32768, 0, 0, 0);
    // A zero tick leaves the position alone; an unused index is ignored.
    row_cfg(REG_TICK, 0);
    row_cfg(REG_START_X, -1);
    row_cfg(REG_START_Y, 1);
    row_cfg(REG_UNUSED, -1);
    row_item(1, CMD_CAPTURE, 1234, 0, 0, -1, 1, 0);
    row_item(1, CMD_INTEGRATE, 6234, 32767, 32767, -1, 1, 5000);
    row_cfg(REG_TICK, 1);
    row_item(0, CMD_INTEGRATE, -1234, -32768, -32768, 0, 0, 0);
    row_item(0, CMD_INTEGRATE, 0, 1, 0, 0, 0, 0);
    row_item(0, CMD_INTEGRATE, 0, -1, 0, 0, 0, 0);

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.kind == ROW_CFG) begin
        settle_block();
        write_reg(row.idx, row.data);
      end else begin
        directed_wants.push_back('{typed: row.typed, pose: row.want});
        offer_item(row.cmd, row.raw, row.sl, row.sr);
      end
    end
    settle_block();

    for (int phase = 0; phase < 13; phase++) begin
      case ($urandom_range(0, 4))
        0: tick = 0;
        1: tick = 1;
        2: tick = 65535;
        3: tick = 5000;
        default: tick = $urandom_range(0, 65535);
      endcase
      write_reg(REG_TICK, IO_POS_W'(tick));
      write_reg(REG_START_X, IO_POS_W'(draw_start()));
      write_reg(REG_START_Y, IO_POS_W'(draw_start()));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, IO_POS_W'({$urandom, $urandom}));
      for (int i = 0; i < 150; i++) begin
        tx_quiet = ((i / 30) % 3 == 1);
        rx_quiet = ((i / 25) % 3 == 2);
        // Long receiver stall while requests keep coming, so the block backs up.
        if (phase == 2 && i == 40) rx_hold_req = 1'b1;
        if (phase == 5 && i == 75) settle_block();
        cmd = ($urandom_range(0, 19) == 0) ? CMD_CAPTURE : CMD_INTEGRATE;
        offer_item(cmd, ANG_W'($urandom), draw_speed(), draw_speed());
      end
      settle_block();
    end

    repeat (40) @(posedge clk_i);
    if (error_count == 0 && expected_poses.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
